/* rtl/sorted_key_table_macros.svh */
// Assertion helpers used by the checker file.
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define SKT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted_key_table: same-cycle check failed");

// Next-cycle implication, checked only out of reset.
`define SKT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted_key_table: next-cycle check failed");

`endif

/* rtl/skt_pkg.sv */
`default_nettype none

package skt_pkg;

    // Table geometry
    localparam int CAPACITY = 64;
    localparam int KEY_W    = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 3;
    localparam int STAT_W   = 2;

    // Request codes
    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd2;
    localparam logic [OP_W-1:0] OP_REWIND = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd3;

    // One result item
    typedef struct packed {
        logic                     found;
        logic signed [KEY_W-1:0]  value;
        logic [CNT_W-1:0]         count;
        logic [STAT_W-1:0]        status;
    } t_result;

    // Key store access for one cycle
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [KEY_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

/* rtl/skt_req_if.sv */
`default_nettype none

interface skt_req_if;
    logic                              valid;
    logic                              ready;
    logic [skt_pkg::OP_W-1:0]          op;
    logic signed [skt_pkg::KEY_W-1:0]  key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

`default_nettype wire

/* rtl/skt_rsp_if.sv */
`default_nettype none

interface skt_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               found;
    logic signed [skt_pkg::KEY_W-1:0]   value;
    logic [skt_pkg::CNT_W-1:0]          count;
    logic [skt_pkg::STAT_W-1:0]         status;

    modport source (output valid, output found, output value, output count, output status,
                    input ready);
    modport sink   (input valid, input found, input value, input count, input status,
                    output ready);
endinterface

`default_nettype wire

/* rtl/skt_ram.sv */
`default_nettype none

// Simple dual-port RAM: one write port, one registered read port.
module skt_ram #(
    parameter  int DEPTH = 64,
    parameter  int WIDTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output      logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/skt_seq.sv */
`default_nettype none

// Request sequencer: walks the key store one entry per cycle.
module skt_seq (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output      logic                              o_ready,
    input  wire logic [skt_pkg::OP_W-1:0]          i_op,
    input  wire logic signed [skt_pkg::KEY_W-1:0]  i_key,
    input  wire logic                              i_out_free,
    output      logic                              o_done,
    output      skt_pkg::t_result                  o_res,
    output      skt_pkg::t_mem_req                 o_mem,
    input  wire logic [skt_pkg::KEY_W-1:0]         i_rdata
);

    localparam int A_W = skt_pkg::ADDR_W;
    localparam int C_W = skt_pkg::CNT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;  // shift larger keys up from the tail
    localparam logic [2:0] S_INSW = 3'd2;  // drop the new key into the hole
    localparam logic [2:0] S_SCAN = 3'd3;  // search from the head
    localparam logic [2:0] S_DSH  = 3'd4;  // close the gap after a delete
    localparam logic [2:0] S_RDN  = 3'd5;  // read-next data return
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]                     r_state, n_state;
    logic [C_W-1:0]                 r_count, n_count;
    logic [C_W-1:0]                 r_cursor, n_cursor;
    logic [C_W-1:0]                 r_idx, n_idx;
    logic [C_W-1:0]                 r_hole, n_hole;
    logic [skt_pkg::OP_W-1:0]       r_op, n_op;
    logic signed [skt_pkg::KEY_W-1:0] r_key, n_key;
    skt_pkg::t_result               r_res, n_res;

    logic signed [skt_pkg::KEY_W-1:0] rd_key;
    logic [C_W-1:0]                 idx_p1;
    logic                           idx_last;
    logic [C_W-1:0]                 hole_m1;
    logic [C_W-1:0]                 rd_pos;

    assign rd_key   = $signed(i_rdata);
    assign idx_p1   = C_W'(r_idx + 1'b1);
    assign idx_last = (idx_p1 == r_count);
    assign hole_m1  = C_W'(r_hole - 1'b1);
    assign rd_pos   = (r_cursor < r_count) ? r_cursor : '0;

    // Next-state and memory access decode
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_cursor = r_cursor;
        n_idx    = r_idx;
        n_hole   = r_hole;
        n_op     = r_op;
        n_key    = r_key;
        n_res    = r_res;
        o_mem    = '0;
        o_done   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op         = i_op;
                    n_key        = i_key;
                    n_res.found  = 1'b0;
                    n_res.value  = '0;
                    n_res.count  = r_count;
                    n_res.status = skt_pkg::ST_OK;
                    n_state      = S_DONE;
                    case (i_op)
                        skt_pkg::OP_INSERT: begin
                            if (r_count == C_W'(skt_pkg::CAPACITY)) begin
                                n_res.status = skt_pkg::ST_FULL;
                            end else if (r_count == '0) begin
                                n_hole  = '0;
                                n_state = S_INSW;
                            end else begin
                                o_mem.re    = 1'b1;
                                o_mem.raddr = A_W'(r_count - 1'b1);
                                n_hole      = r_count;
                                n_state     = S_INS;
                            end
                        end
                        skt_pkg::OP_DELETE, skt_pkg::OP_LOOKUP: begin
                            if (r_count == '0) begin
                                n_res.status = skt_pkg::ST_MISSING;
                            end else begin
                                o_mem.re    = 1'b1;
                                o_mem.raddr = '0;
                                n_idx       = '0;
                                n_state     = S_SCAN;
                            end
                        end
                        skt_pkg::OP_REWIND: begin
                            n_cursor = '0;
                        end
                        skt_pkg::OP_READ: begin
                            if (r_count == '0) begin
                                n_res.status = skt_pkg::ST_EMPTY;
                            end else begin
                                o_mem.re    = 1'b1;
                                o_mem.raddr = rd_pos[A_W-1:0];
                                n_cursor    = C_W'(rd_pos + 1'b1);
                                n_state     = S_RDN;
                            end
                        end
                        skt_pkg::OP_CLEAR: begin
                            n_count     = '0;
                            n_cursor    = '0;
                            n_res.count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_INS: begin
                if (rd_key > r_key) begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_hole[A_W-1:0];
                    o_mem.wdata = i_rdata;
                    n_hole      = hole_m1;
                    if (hole_m1 == '0) begin
                        n_state = S_INSW;
                    end else begin
                        o_mem.re    = 1'b1;
                        o_mem.raddr = A_W'(r_hole - 2'd2);
                    end
                end else begin
                    o_mem.we    = 1'b1;
                    o_mem.waddr = r_hole[A_W-1:0];
                    o_mem.wdata = r_key;
                    n_count     = C_W'(r_count + 1'b1);
                    n_res.count = C_W'(r_count + 1'b1);
                    n_state     = S_DONE;
                end
            end

            S_INSW: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_hole[A_W-1:0];
                o_mem.wdata = r_key;
                n_count     = C_W'(r_count + 1'b1);
                n_res.count = C_W'(r_count + 1'b1);
                n_state     = S_DONE;
            end

            S_SCAN: begin
                if (rd_key < r_key) begin
                    if (idx_last) begin
                        n_res.status = skt_pkg::ST_MISSING;
                        n_state      = S_DONE;
                    end else begin
                        o_mem.re    = 1'b1;
                        o_mem.raddr = idx_p1[A_W-1:0];
                        n_idx       = idx_p1;
                    end
                end else if (rd_key == r_key) begin
                    n_res.found = 1'b1;
                    if (r_op == skt_pkg::OP_LOOKUP) begin
                        n_res.value = rd_key;
                        n_state     = S_DONE;
                    end else if (idx_last) begin
                        // tail entry removed: nothing to shift
                        n_count     = C_W'(r_count - 1'b1);
                        n_res.count = C_W'(r_count - 1'b1);
                        n_state     = S_DONE;
                    end else begin
                        o_mem.re    = 1'b1;
                        o_mem.raddr = idx_p1[A_W-1:0];
                        n_idx       = idx_p1;
                        n_state     = S_DSH;
                    end
                end else begin
                    n_res.status = skt_pkg::ST_MISSING;
                    n_state      = S_DONE;
                end
            end

            S_DSH: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = A_W'(r_idx - 1'b1);
                o_mem.wdata = i_rdata;
                if (idx_last) begin
                    n_count     = C_W'(r_count - 1'b1);
                    n_res.count = C_W'(r_count - 1'b1);
                    n_state     = S_DONE;
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = idx_p1[A_W-1:0];
                    n_idx       = idx_p1;
                end
            end

            S_RDN: begin
                n_res.found = 1'b1;
                n_res.value = rd_key;
                n_state     = S_DONE;
            end

            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
        end
    end

    // Working payload
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_hole <= n_hole;
        r_op   <= n_op;
        r_key  <= n_key;
        r_res  <= n_res;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_res   = r_res;

endmodule

`default_nettype wire

/* rtl/sorted_key_table.sv */
`default_nettype none

// Sorted key table: up to 64 signed 32-bit keys held in ascending order in one
// dual-port RAM, with one result per request. Requests are served one at a time,
// and the RAM walk (one entry per cycle) sets the latency: insert walks from the tail
// past each stored key greater than the new key, delete and lookup walk from the
// head to the key, and delete then moves each later key one place toward the head;
// read next, rewind, clear and a full/empty rejection need no walk. The next
// request is taken the cycle after the result moves into the output register, so
// a waiting result does not stop the next request from being taken and worked.
// The read cursor keeps its index across inserts and deletes and wraps to the
// head once it passes the last entry.
module sorted_key_table (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    skt_req_if.sink   i_req,
    skt_rsp_if.source o_rsp
);

    logic                  seq_done;
    logic                  out_free;
    skt_pkg::t_result      seq_res;
    skt_pkg::t_mem_req     mem_req;
    logic [skt_pkg::KEY_W-1:0] mem_rdata;

    logic                  r_out_valid;
    skt_pkg::t_result      r_out;

    assign out_free = !r_out_valid || o_rsp.ready;

    skt_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_req.valid),
        .o_ready    (i_req.ready),
        .i_op       (i_req.op),
        .i_key      (i_req.key),
        .i_out_free (out_free),
        .o_done     (seq_done),
        .o_res      (seq_res),
        .o_mem      (mem_req),
        .i_rdata    (mem_rdata)
    );

    skt_ram #(
        .DEPTH (skt_pkg::CAPACITY),
        .WIDTH (skt_pkg::KEY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_done) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done) begin
            r_out <= seq_res;
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.found  = r_out.found;
    assign o_rsp.value  = r_out.value;
    assign o_rsp.count  = r_out.count;
    assign o_rsp.status = r_out.status;

endmodule

`default_nettype wire

/* rtl/skt_checker.sv */
`default_nettype none

`include "sorted_key_table_macros.svh"

// Port-level checks on the result channel.
module skt_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_rsp_valid,
    input wire logic                              i_rsp_ready,
    input wire logic                              i_rsp_found,
    input wire logic signed [skt_pkg::KEY_W-1:0]  i_rsp_value,
    input wire logic [skt_pkg::CNT_W-1:0]         i_rsp_count,
    input wire logic [skt_pkg::STAT_W-1:0]        i_rsp_status
);

    // count never goes past the table size
    `SKT_ASSERT_NOW(a_count_bound, i_rsp_valid, i_rsp_count <= skt_pkg::CNT_W'(skt_pkg::CAPACITY))

    // any rejected request reports no match and a zero value
    `SKT_ASSERT_NOW(a_reject_clean, i_rsp_valid && i_rsp_status != skt_pkg::ST_OK, !i_rsp_found && i_rsp_value == '0)

    // empty status only when nothing is stored
    `SKT_ASSERT_NOW(a_empty_count, i_rsp_valid && i_rsp_status == skt_pkg::ST_EMPTY, i_rsp_count == '0)

    // a stalled result holds
    `SKT_ASSERT_NEXT(a_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_count) && $stable(i_rsp_value) && $stable(i_rsp_status))

endmodule

bind sorted_key_table skt_checker u_skt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_found  (o_rsp.found),
    .i_rsp_value  (o_rsp.value),
    .i_rsp_count  (o_rsp.count),
    .i_rsp_status (o_rsp.status)
);

`default_nettype wire
